/* rtl/mhfr_pkg.sv */
// Shared types and constants for the magic-header frame receiver.
// No dependencies; imported by every module of the block.
package mhfr_pkg;

    // Default size of the payload store, in bytes
    localparam int MSG_DEPTH_DEF = 1024;

    // Fixed field widths
    localparam int MODE_W  = 2;
    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 10;
    localparam int PHASE_W = 3;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_OFFER   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;

    // Parser phase codes as they show on parser_phase
    localparam logic [PHASE_W-1:0] PHASE_IDLE    = 3'd0;
    localparam logic [PHASE_W-1:0] PHASE_MAGIC1  = 3'd1;
    localparam logic [PHASE_W-1:0] PHASE_MAGIC2  = 3'd2;
    localparam logic [PHASE_W-1:0] PHASE_VERSION = 3'd3;
    localparam logic [PHASE_W-1:0] PHASE_PAYLOAD = 3'd4;
    localparam logic [PHASE_W-1:0] PHASE_HELD    = 3'd5;

    // Header and terminator bytes
    localparam logic [BYTE_W-1:0] HDR_MAGIC0   = 8'hDC;
    localparam logic [BYTE_W-1:0] HDR_MAGIC1   = 8'hCD;
    localparam logic [BYTE_W-1:0] HDR_VERSION  = 8'h01;
    localparam logic [BYTE_W-1:0] OPT_SHORT    = 8'h03;
    localparam logic [BYTE_W-1:0] OPT_LONG     = 8'h07;
    localparam logic [BYTE_W-1:0] PAYLOAD_TERM = 8'h00;

    // Result queue geometry
    localparam int RESQ_DEPTH = 3;
    localparam int RESQ_PTR_W = $clog2(RESQ_DEPTH);
    localparam int RESQ_CNT_W = $clog2(RESQ_DEPTH + 1);

    // One result word
    typedef struct packed {
        logic               accepted;
        logic               frame_ready;
        logic [BYTE_W-1:0]  read_data;
        logic [BYTE_W-1:0]  option_byte;
        logic [INDEX_W-1:0] stored_count;
        logic [PHASE_W-1:0] parser_phase;
    } res_t;

endpackage

/* rtl/mhfr_resq.sv */
// Three-entry result queue that decouples the receiver core from the output.
// Depends on mhfr_pkg (res_t, queue geometry).
module mhfr_resq
    import mhfr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  res_t                  push_data,
    input  logic                  pop,
    output logic                  head_valid,
    output res_t                  head_data,
    output logic [RESQ_CNT_W-1:0] fill
);

    res_t                  entry_reg [RESQ_DEPTH];
    logic [RESQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [RESQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [RESQ_CNT_W-1:0] cnt_reg, cnt_next;

    function automatic logic [RESQ_PTR_W-1:0] ptr_inc(input logic [RESQ_PTR_W-1:0] p);
        ptr_inc = (p == RESQ_PTR_W'(RESQ_DEPTH - 1)) ? '0 : p + RESQ_PTR_W'(1);
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg + RESQ_CNT_W'(push) - RESQ_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head_valid = (cnt_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];
    assign fill       = cnt_reg;

endmodule

/* rtl/magic_header_frame_receiver.sv */
// Top level of the magic-header frame receiver: header hunt, payload store,
// held-frame reads. Depends on mhfr_pkg and mhfr_resq.
//
//  channel | direction | handshake            | word fields
//  --------+-----------+----------------------+------------------------------------------
//  input   | in        | in_valid / in_stall  | mode, byte_value, read_index
//  output  | out       | out_valid / out_stall| accepted, frame_ready, read_data,
//          |           |                      | option_byte, stored_count, parser_phase
//
// Flow: one word per clock is taken while in_stall is low; its result word is registered
//   in the s1 stage beside the payload store read, then in the result queue before it is offered.
// Reset: rst_n clears the parser phase, write index, option byte and the queue. The
//   payload store is not cleared; only entries written in the held frame are read.
// Stalls: in_stall rises when the result queue plus the word in flight would fill it,
//   so an output stall reaches the input after up to two more words are taken.
module magic_header_frame_receiver
    import mhfr_pkg::*;
#(
    parameter int MSG_DEPTH = MSG_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    // input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [MODE_W-1:0]  mode,
    input  logic [BYTE_W-1:0]  byte_value,
    input  logic [INDEX_W-1:0] read_index,
    // output channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic               accepted,
    output logic               frame_ready,
    output logic [BYTE_W-1:0]  read_data,
    output logic [BYTE_W-1:0]  option_byte,
    output logic [INDEX_W-1:0] stored_count,
    output logic [PHASE_W-1:0] parser_phase
);

    // Write index width and a common width for index compares
    localparam int WIDX_W = $clog2(MSG_DEPTH);
    localparam int CMP_W  = (WIDX_W > INDEX_W) ? WIDX_W : INDEX_W;
    localparam logic [WIDX_W-1:0] WIDX_LAST = WIDX_W'(MSG_DEPTH - 1);

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE    = PHASE_IDLE,
        PH_MAGIC1  = PHASE_MAGIC1,
        PH_MAGIC2  = PHASE_MAGIC2,
        PH_VERSION = PHASE_VERSION,
        PH_PAYLOAD = PHASE_PAYLOAD,
        PH_HELD    = PHASE_HELD
    } phase_t;

    // Parser state
    phase_t             phase_reg, phase_next;
    logic [WIDX_W-1:0]  widx_reg, widx_next;
    logic [BYTE_W-1:0]  opt_reg, opt_next;

    // Per-word decode
    logic               take;
    logic               acc_flag;
    logic               rd_en;
    logic               mem_we;
    logic [CMP_W-1:0]   idx_ext;
    logic [CMP_W-1:0]   widx_ext;

    // Payload store and its registered read port
    logic [BYTE_W-1:0]  mem [MSG_DEPTH];
    logic [BYTE_W-1:0]  mem_rd_reg;

    // Stage between store read and result queue
    logic               s1_valid_reg;
    logic               s1_rd_en_reg;
    res_t               s1_res_reg;
    res_t               s1_res_next;
    res_t               push_res;

    // Result queue
    logic                  q_pop;
    logic                  q_valid;
    res_t                  q_head;
    logic [RESQ_CNT_W-1:0] q_fill;
    logic [RESQ_CNT_W:0]   q_load;

    assign take     = in_valid && !in_stall;
    assign idx_ext  = CMP_W'(read_index);
    assign widx_ext = CMP_W'(widx_reg);

    // Next parser state and the flags this word raises
    always_comb
    begin
        phase_next = phase_reg;
        widx_next  = widx_reg;
        opt_next   = opt_reg;
        acc_flag   = 1'b0;
        rd_en      = 1'b0;
        mem_we     = 1'b0;
        case (mode)
            MODE_OFFER:
            begin
                if (phase_reg != PH_HELD)
                begin
                    acc_flag = 1'b1;
                    case (phase_reg)
                        PH_IDLE:
                        begin
                            if (byte_value == HDR_MAGIC0)
                            begin
                                phase_next = PH_MAGIC1;
                            end
                        end
                        PH_MAGIC1:
                        begin
                            phase_next = (byte_value == HDR_MAGIC1) ? PH_MAGIC2 : PH_IDLE;
                        end
                        PH_MAGIC2:
                        begin
                            phase_next = (byte_value == HDR_VERSION) ? PH_VERSION : PH_IDLE;
                        end
                        PH_VERSION:
                        begin
                            if (byte_value inside {OPT_SHORT, OPT_LONG})
                            begin
                                phase_next = PH_PAYLOAD;
                                opt_next   = byte_value;
                                widx_next  = '0;
                            end
                            else
                            begin
                                phase_next = PH_IDLE;
                            end
                        end
                        PH_PAYLOAD:
                        begin
                            // Store at the write index; stop advancing at the last entry
                            mem_we = 1'b1;
                            if (widx_reg != WIDX_LAST)
                            begin
                                widx_next = widx_reg + WIDX_W'(1);
                            end
                            if (byte_value == PAYLOAD_TERM)
                            begin
                                phase_next = PH_HELD;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
            end
            MODE_READ:
            begin
                // Only stored bytes of the held frame read back
                rd_en = (phase_reg == PH_HELD) && (idx_ext < widx_ext);
            end
            MODE_RELEASE:
            begin
                if (phase_reg == PH_HELD)
                begin
                    phase_next = PH_IDLE;
                    acc_flag   = 1'b1;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    // Result fields reflect the state after this word
    always_comb
    begin
        s1_res_next.accepted     = acc_flag;
        s1_res_next.frame_ready  = (phase_next == PH_HELD);
        s1_res_next.read_data    = '0;
        s1_res_next.option_byte  = opt_next;
        s1_res_next.stored_count = INDEX_W'(widx_next);
        s1_res_next.parser_phase = phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            widx_reg     <= '0;
            opt_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= take;
            if (take)
            begin
                phase_reg <= phase_next;
                widx_reg  <= widx_next;
                opt_reg   <= opt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_res_reg   <= s1_res_next;
            s1_rd_en_reg <= rd_en;
        end
    end

    // Payload store: one write port, one registered read port. Writes happen only
    // while collecting payload and reads only while held, so they never collide.
    always_ff @(posedge clk)
    begin
        if (take && mem_we)
        begin
            mem[widx_reg] <= byte_value;
        end
        if (take && rd_en)
        begin
            mem_rd_reg <= mem[idx_ext[WIDX_W-1:0]];
        end
    end

    // Merge the store read into the result word
    always_comb
    begin
        push_res           = s1_res_reg;
        push_res.read_data = s1_rd_en_reg ? mem_rd_reg : '0;
    end

    assign q_pop = q_valid && !out_stall;

    mhfr_resq u_resq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (s1_valid_reg),
        .push_data  (push_res),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_head),
        .fill       (q_fill)
    );

    // Hold the input while the queue and the word in flight could fill it
    assign q_load   = {1'b0, q_fill} + (RESQ_CNT_W + 1)'(s1_valid_reg);
    assign in_stall = (q_load > (RESQ_CNT_W + 1)'(RESQ_DEPTH - 1));

    assign out_valid    = q_valid;
    assign accepted     = q_head.accepted;
    assign frame_ready  = q_head.frame_ready;
    assign read_data    = q_head.read_data;
    assign option_byte  = q_head.option_byte;
    assign stored_count = q_head.stored_count;
    assign parser_phase = q_head.parser_phase;

endmodule

/* rtl/mhfr_chk.sv */
// Port-level checker for the magic-header frame receiver, bound to the top level.
// Depends on mhfr_pkg (phase codes, option bytes, field widths).
module mhfr_chk
    import mhfr_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic [MODE_W-1:0]  mode,
    input logic [BYTE_W-1:0]  byte_value,
    input logic [INDEX_W-1:0] read_index,
    input logic               out_valid,
    input logic               out_stall,
    input logic               accepted,
    input logic               frame_ready,
    input logic [BYTE_W-1:0]  read_data,
    input logic [BYTE_W-1:0]  option_byte,
    input logic [PHASE_W-1:0] parser_phase
);

    // A stalled input word stays offered and unchanged
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(mode) && $stable(byte_value)
            && $stable(read_index))
        else $error("input word changed while stalled");

    // A stalled result word stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word dropped while stalled");

    // frame_ready tracks the held phase exactly
    a_ready_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (frame_ready == (parser_phase == PHASE_HELD)))
        else $error("frame_ready disagrees with parser_phase");

    // Nonzero read data only comes from a read of a held frame
    a_read_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (read_data != '0) |-> (parser_phase == PHASE_HELD) && !accepted)
        else $error("read data outside a held frame");

    // Collecting payload means a valid option byte was seen
    a_payload_opt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (parser_phase == PHASE_PAYLOAD)
            |-> (option_byte == OPT_SHORT) || (option_byte == OPT_LONG))
        else $error("payload phase with invalid option byte");

endmodule

bind magic_header_frame_receiver mhfr_chk u_mhfr_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .byte_value   (byte_value),
    .read_index   (read_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .accepted     (accepted),
    .frame_ready  (frame_ready),
    .read_data    (read_data),
    .option_byte  (option_byte),
    .parser_phase (parser_phase)
);

/* tb/sv/frame_receiver_checker.sv */
`timescale 1ns / 100ps
// Checker for the magic-header frame receiver: tracks the header hunt and payload store,
// predicts one result word per accepted input word and compares it on the output side.
// Depends on mhfr_pkg.
module frame_receiver_checker
    import mhfr_pkg::*;
#(
    parameter int MSG_DEPTH = MSG_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [MODE_W-1:0]  mode,
    input  logic [BYTE_W-1:0]  byte_value,
    input  logic [INDEX_W-1:0] read_index,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic               accepted,
    input  logic               frame_ready,
    input  logic [BYTE_W-1:0]  read_data,
    input  logic [BYTE_W-1:0]  option_byte,
    input  logic [INDEX_W-1:0] stored_count,
    input  logic [PHASE_W-1:0] parser_phase,
    output int                 fail_count,
    output int                 pending_results
);

    logic [PHASE_W-1:0] rx_phase;
    logic [BYTE_W-1:0]  payload_store [MSG_DEPTH];
    int unsigned        wr_index;
    logic [BYTE_W-1:0]  opt_seen;
    res_t               predicted_results [$];
    res_t               want;
    int                 mismatches;

    // Advance the receiver by one input word and return the result word it yields.
    function automatic res_t step_receiver(input logic [MODE_W-1:0] m,
                                           input logic [BYTE_W-1:0] b,
                                           input logic [INDEX_W-1:0] idx);
        res_t r;
        r = '0;
        case (m)
            MODE_OFFER:
                if (rx_phase != PHASE_HELD)
                begin
                    r.accepted = 1'b1;
                    case (rx_phase)
                        PHASE_IDLE:
                            if (b == HDR_MAGIC0)
                                rx_phase = PHASE_MAGIC1;
                        PHASE_MAGIC1:
                            rx_phase = (b == HDR_MAGIC1) ? PHASE_MAGIC2 : PHASE_IDLE;
                        PHASE_MAGIC2:
                            rx_phase = (b == HDR_VERSION) ? PHASE_VERSION : PHASE_IDLE;
                        PHASE_VERSION:
                            if (b == OPT_SHORT || b == OPT_LONG)
                            begin
                                rx_phase = PHASE_PAYLOAD;
                                opt_seen = b;
                                wr_index = 0;
                            end
                            else
                            begin
                                rx_phase = PHASE_IDLE;
                            end
                        PHASE_PAYLOAD:
                        begin
                            // the write index sticks at the last entry
                            payload_store[wr_index] = b;
                            if (wr_index < MSG_DEPTH - 1)
                                wr_index++;
                            if (b == PAYLOAD_TERM)
                                rx_phase = PHASE_HELD;
                        end
                        default:
                            rx_phase = PHASE_IDLE;
                    endcase
                end
            MODE_READ:
                if (rx_phase == PHASE_HELD && idx < wr_index && idx < MSG_DEPTH)
                    r.read_data = payload_store[idx];
            MODE_RELEASE:
                if (rx_phase == PHASE_HELD)
                begin
                    rx_phase = PHASE_IDLE;
                    r.accepted = 1'b1;
                end
            default:
                ;
        endcase
        r.frame_ready  = (rx_phase == PHASE_HELD);
        r.option_byte  = opt_seen;
        r.stored_count = INDEX_W'(wr_index);
        r.parser_phase = rx_phase;
        return r;
    endfunction

    task automatic check_field(input string field, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (want_v !== got_v)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_phase = PHASE_IDLE;
            wr_index = 0;
            opt_seen = '0;
            mismatches = 0;
            predicted_results.delete();
            pending_results <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predicted_results.push_back(step_receiver(mode, byte_value, read_index));
            if (out_valid && !out_stall)
            begin
                if (predicted_results.size() == 0)
                begin
                    $display("%0t: result word with none expected, expected none actual %0h",
                             $time, {accepted, frame_ready, read_data, option_byte,
                                     stored_count, parser_phase});
                    mismatches++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    check_field("accepted", 16'(want.accepted), 16'(accepted));
                    check_field("frame_ready", 16'(want.frame_ready), 16'(frame_ready));
                    check_field("read_data", 16'(want.read_data), 16'(read_data));
                    check_field("option_byte", 16'(want.option_byte), 16'(option_byte));
                    check_field("stored_count", 16'(want.stored_count), 16'(stored_count));
                    check_field("parser_phase", 16'(want.parser_phase), 16'(parser_phase));
                end
            end
            pending_results <= predicted_results.size();
            fail_count <= mismatches;
        end
    end

endmodule

/* tb/sv/tb_magic_header_frame_receiver.sv */
`timescale 1ns / 100ps
// Top of the frame receiver testbench: clock, reset, stimulus and the final verdict.
// Depends on mhfr_pkg, magic_header_frame_receiver and frame_receiver_checker.
module tb_magic_header_frame_receiver;
    import mhfr_pkg::*;

    typedef logic [BYTE_W-1:0] byte_q_t [$];

    // mode code the block has no use for; it must be ignored
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam int RANDOM_WORDS     = 1200;
    localparam int OVERFLOW_PAYLOAD = 1030;   // long enough to pin the write index
    localparam int OVERFLOW_AT      = 100;
    localparam int CALM_FROM        = 250;    // no idling on either side in this span
    localparam int CALM_TO          = 400;
    localparam int IDLE_PCT         = 37;
    localparam int WATCHDOG_LIMIT   = 5000;
    localparam int DRAIN_CYCLES     = 8;      // result passes the s1 stage and the result queue

    logic               clk;
    logic               rst_n = 1'b0;
    logic               in_valid;
    logic               in_stall;
    logic [MODE_W-1:0]  mode;
    logic [BYTE_W-1:0]  byte_value;
    logic [INDEX_W-1:0] read_index;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               accepted;
    logic               frame_ready;
    logic [BYTE_W-1:0]  read_data;
    logic [BYTE_W-1:0]  option_byte;
    logic [INDEX_W-1:0] stored_count;
    logic [PHASE_W-1:0] parser_phase;

    int fail_count;
    int pending_results;

    // Stimulus bookkeeping: what the sender knows about the frame it built.
    int words_sent;
    bit calm;
    bit holding;
    int held_count;      // write index of the frame being held
    int written_span;    // entries 0 .. written_span-1 have been written since reset
    int quiet_cycles = 0;

    magic_header_frame_receiver DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .byte_value   (byte_value),
        .read_index   (read_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .accepted     (accepted),
        .frame_ready  (frame_ready),
        .read_data    (read_data),
        .option_byte  (option_byte),
        .stored_count (stored_count),
        .parser_phase (parser_phase)
    );

    frame_receiver_checker u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .mode            (mode),
        .byte_value      (byte_value),
        .read_index      (read_index),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .accepted        (accepted),
        .frame_ready     (frame_ready),
        .read_data       (read_data),
        .option_byte     (option_byte),
        .stored_count    (stored_count),
        .parser_phase    (parser_phase),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver side: stall at random, except in the calm span.
    always @(posedge clk)
        out_stall <= calm ? 1'b0 : ($urandom_range(99) < IDLE_PCT);

    // Watchdog: count cycles in which neither channel moves a word.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Offer one word: idle first at random, then hold the word until it is taken.
    task automatic send_word(input logic [MODE_W-1:0] m, input logic [BYTE_W-1:0] b,
                             input logic [INDEX_W-1:0] idx);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= m;
        byte_value <= b;
        read_index <= idx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // words the block just drops do not count toward the run length
        if (m != MODE_UNUSED && !(m == MODE_RELEASE && !holding))
            words_sent++;
        calm <= (words_sent >= CALM_FROM && words_sent < CALM_TO);
    endtask

    task automatic send_offer(input logic [BYTE_W-1:0] b);
        send_word(MODE_OFFER, b, INDEX_W'($urandom_range(1023)));
    endtask

    task automatic send_read(input logic [INDEX_W-1:0] idx);
        send_word(MODE_READ, BYTE_W'($urandom_range(255)), idx);
    endtask

    task automatic send_release();
        send_word(MODE_RELEASE, BYTE_W'($urandom_range(255)), INDEX_W'($urandom_range(1023)));
        holding = 1'b0;
    endtask

    // Pick a read position that was written at some point since reset; mostly one
    // inside the held frame, otherwise any written one, which may be stale past its stored count.
    function automatic logic [INDEX_W-1:0] pick_read_index();
        if (holding && held_count > 0 && $urandom_range(3) != 0)
            return INDEX_W'($urandom_range(held_count - 1));
        return INDEX_W'($urandom_range(written_span - 1));
    endfunction

    // A word that is no stream byte: a read, a release, or the unused mode.
    task automatic send_stray();
        int pick;
        pick = $urandom_range(2);
        if (pick == 0 && written_span > 0)
            send_read(pick_read_index());
        else if (pick == 1 && !holding)
            send_release();
        else
            send_word(MODE_UNUSED, BYTE_W'($urandom_range(255)),
                      INDEX_W'($urandom_range(1023)));
    endtask

    // Send a full frame: header, payload with the odd stray word, terminator.
    task automatic send_frame(input logic [BYTE_W-1:0] opt, input byte_q_t payload);
        int n;
        send_offer(HDR_MAGIC0);
        send_offer(HDR_MAGIC1);
        send_offer(HDR_VERSION);
        send_offer(opt);
        foreach (payload[i])
        begin
            if ($urandom_range(9) == 0)
                send_stray();
            send_offer(payload[i]);
        end
        send_offer(PAYLOAD_TERM);
        n = payload.size() + 1;
        held_count = (n < MSG_DEPTH_DEF) ? n : MSG_DEPTH_DEF - 1;
        if (written_span < n)
            written_span = (n < MSG_DEPTH_DEF) ? n : MSG_DEPTH_DEF;
        holding = 1'b1;
    endtask

    // Stop sending and hold off until every predicted result word has come back.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
    endtask

    initial
    begin
        byte_q_t payload;
        int      roll;
        int      len;
        int      plen;
        int      extra;
        bit      overflow_done;
        logic [BYTE_W-1:0] wrong;

        in_valid   <= 1'b0;
        mode       <= MODE_OFFER;
        byte_value <= '0;
        read_index <= '0;
        calm       <= 1'b0;
        words_sent = 0;
        holding = 1'b0;
        held_count = 0;
        written_span = 0;
        overflow_done = 1'b0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        // release with no frame held, unused mode with all ones, zero byte in idle
        send_word(MODE_RELEASE, 8'hFF, 10'h3FF);
        send_word(MODE_UNUSED, 8'hFF, 10'h3FF);
        send_offer(8'h00);
        // header restart: a second magic byte drops back to idle
        send_offer(HDR_MAGIC0);
        send_offer(HDR_MAGIC0);
        // long-option frame, then a refused byte while held
        payload = '{8'hFF, 8'h01, 8'h80};
        send_frame(OPT_LONG, payload);
        send_offer(HDR_MAGIC0);
        send_read(10'd0);
        send_read(10'd3);     // the terminator itself
        send_release();
        // short-option frame; read past its stored count into stale entries
        payload = '{8'hAB};
        send_frame(OPT_SHORT, payload);
        send_read(10'd2);
        send_release();
        send_release();       // nothing held any more
        drain();

        // ---- random part ----
        while (words_sent < RANDOM_WORDS)
        begin
            if (!overflow_done && words_sent >= OVERFLOW_AT)
            begin
                // overflow: the last entry keeps getting overwritten
                payload.delete();
                repeat (OVERFLOW_PAYLOAD)
                    payload.push_back(BYTE_W'($urandom_range(255, 1)));
                send_frame(OPT_LONG, payload);
                send_read(10'd1022);
                send_read(10'd1023);
                send_read(10'd0);
                send_read(pick_read_index());
                send_offer(BYTE_W'($urandom_range(255)));
                drain();
                send_release();
                overflow_done = 1'b1;
            end

            roll = $urandom_range(99);
            if (roll < 55)
            begin
                // well-formed frame, mostly short
                len = ($urandom_range(19) == 0) ? $urandom_range(80, 13) : $urandom_range(12);
                payload.delete();
                repeat (len)
                    payload.push_back(BYTE_W'($urandom_range(255, 1)));
                send_frame($urandom_range(1) ? OPT_LONG : OPT_SHORT, payload);
                extra = $urandom_range(5);
                repeat (extra)
                begin
                    roll = $urandom_range(99);
                    if (roll < 60)
                        send_read(pick_read_index());
                    else if (roll < 80)
                        send_offer(BYTE_W'($urandom_range(255)));
                    else
                        send_word(MODE_UNUSED, BYTE_W'($urandom_range(255)),
                                  INDEX_W'($urandom_range(1023)));
                end
                send_release();
            end
            else if (roll < 75)
            begin
                // broken header: a good prefix, then a byte that does not fit
                plen = $urandom_range(3, 1);
                send_offer(HDR_MAGIC0);
                if (plen >= 2)
                    send_offer(HDR_MAGIC1);
                if (plen >= 3)
                    send_offer(HDR_VERSION);
                wrong = ($urandom_range(3) == 0) ? HDR_MAGIC0 : BYTE_W'($urandom_range(255));
                while ((plen == 1 && wrong == HDR_MAGIC1)
                       || (plen == 2 && wrong == HDR_VERSION)
                       || (plen == 3 && (wrong == OPT_SHORT || wrong == OPT_LONG)))
                    wrong = BYTE_W'($urandom_range(255));
                send_offer(wrong);
            end
            else if (roll < 88)
            begin
                // idle noise byte; keep it from opening a header
                wrong = BYTE_W'($urandom_range(255));
                if (wrong == HDR_MAGIC0)
                    wrong = ~wrong;
                send_offer(wrong);
            end
            else
            begin
                send_stray();
            end
        end

        // ---- wind down ----
        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_results == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* magic_header_frame_receiver.f */
rtl/mhfr_pkg.sv
rtl/mhfr_resq.sv
rtl/magic_header_frame_receiver.sv
rtl/mhfr_chk.sv
tb/sv/frame_receiver_checker.sv
tb/sv/tb_magic_header_frame_receiver.sv
